// File: rtl/core/polygon_scanline_uv_raster_assert.svh
// ----------------------------------------------------------------------------
// polygon_scanline_uv_raster assertion macros
// Shared concurrent assertion forms for the raster core.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SCANLINE_UV_RASTER_ASSERT_SVH
`define POLYGON_SCANLINE_UV_RASTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSUR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psur assertion failed");

// next-cycle implication, disabled during reset
`define PSUR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psur assertion failed");

`endif

// File: rtl/core/psur_pkg.sv
// ----------------------------------------------------------------------------
// psur_pkg
// Types, constants and helpers of the polygon scanline raster core.
// ----------------------------------------------------------------------------
`default_nettype none

package psur_pkg;

    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 128;
    localparam int MAX_VERTICES  = 8;

    localparam int X_W  = $clog2(CANVAS_WIDTH);
    localparam int Y_W  = $clog2(CANVAS_HEIGHT);
    localparam int VI_W = $clog2(MAX_VERTICES);
    localparam int VC_W = $clog2(MAX_VERTICES + 1);

    // divider operand widths
    localparam int DVD_W = 49;
    localparam int DVS_W = 34;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_u;
        logic signed [15:0] vertex_v;
    } req_t;

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
        logic [7:0]     green;
        logic [7:0]     red;
        logic           last;
        logic           empty_res;
    } res_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_u;
        logic signed [15:0] vertex_v;
    } vtx_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } pt_t;

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [50:0] val);
        logic hi_same;
        hi_same = (&val[50:31]) || !(|val[50:31]);
        if (hi_same) begin
            return val[31:0];
        end
        return val[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // two texture bits above the quarter step, placed in the top of a byte
    function automatic logic [7:0] colour(input logic signed [31:0] q20);
        return {q20[19:18], 6'b0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/polygon_scanline_uv_raster.sv
// ----------------------------------------------------------------------------
// polygon_scanline_uv_raster
// Convex polygon scanline filler with affine (u, v) texture coordinates.
// ----------------------------------------------------------------------------
//  channel | ports                     | moves
//  --------+---------------------------+-----------------------------------
//  input   | s_valid s_ready s_data    | vertex load or next-pixel request
//  result  | m_valid m_ready m_data    | one pixel or empty flag per step
//
//  A vertex load leaves the sequencer idle. A step request inside a running
//  span is ready again after find, two products through the shared multiplier,
//  span output, return and emit. Each edge row adds three products and a row
//  store step; a span setup adds two passes of the bit-serial divider (none for
//  a span whose ends lie at the same x), an edge setup three passes.
//  Reset is synchronous and clears control state and row flags only.
//  A finished result waits in the output register while new requests enter;
//  emit stalls only while that register still holds an unaccepted result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_scanline_uv_raster_assert.svh"

module polygon_scanline_uv_raster (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire psur_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output psur_pkg::res_t       m_data
);

    typedef enum logic [1:0] {PH_LOADING, PH_RUNNING, PH_DONE} phase_t;

    typedef enum logic [4:0] {
        S_IDLE, S_FIND, S_RETURN, S_EMIT,
        S_SP_U, S_SP_V, S_SP_OUT,
        S_ER_X, S_ER_U, S_ER_V, S_ER_W,
        S_SS_DUS, S_SS_DUW, S_SS_DVS, S_SS_DVW, S_SS_MU, S_SS_MV, S_SS_FIN,
        S_ES_RD0, S_ES_RD1, S_ES_RD2,
        S_ES_DXS, S_ES_DXW, S_ES_DUS, S_ES_DUW, S_ES_DVS, S_ES_DVW,
        S_ES_MX, S_ES_MU, S_ES_MV, S_ES_FIN
    } state_t;

    localparam int X_W  = psur_pkg::X_W;
    localparam int Y_W  = psur_pkg::Y_W;
    localparam int VI_W = psur_pkg::VI_W;
    localparam int VC_W = psur_pkg::VC_W;

    // control
    state_t                       state_reg;
    phase_t                       phase_reg;
    logic [VC_W-1:0]              vcount_reg;
    logic [VC_W-1:0]              edge_index_reg;
    logic                         edge_on_reg;
    logic                         span_on_reg;
    logic                         first_reg;
    logic                         found_reg;
    logic [psur_pkg::CANVAS_HEIGHT-1:0] row_seen_reg;
    logic                         m_valid_reg;
    psur_pkg::res_t               m_data_reg;
    psur_pkg::res_t               res_reg;

    // memories
    psur_pkg::vtx_t               vmem [psur_pkg::MAX_VERTICES];
    psur_pkg::vtx_t               vrd_reg;
    psur_pkg::pt_t                rmem [psur_pkg::CANVAS_HEIGHT];
    psur_pkg::pt_t                rrd_reg;

    // edge walk
    psur_pkg::vtx_t               q0_reg;
    psur_pkg::vtx_t               top_reg;
    psur_pkg::vtx_t               bot_reg;
    logic signed [31:0]           edge_x0_reg, edge_u0_reg, edge_v0_reg;
    logic signed [31:0]           edge_dx_reg, edge_du_reg, edge_dv_reg;
    logic [10:0]                  edge_row_reg;
    logic [8:0]                   edge_first_reg;
    logic signed [10:0]           edge_end_reg;
    logic signed [31:0]           cur_x_reg, cur_u_reg;

    // span walk
    psur_pkg::pt_t                sa_reg, sb_reg;
    logic signed [31:0]           span_u0_reg, span_v0_reg, span_du_reg, span_dv_reg;
    logic signed [16:0]           span_col_reg, span_c0_reg, span_end_reg;
    logic [Y_W-1:0]               span_y_reg;

    // look-ahead pixel
    logic [X_W-1:0]               pend_x_reg;
    logic [Y_W-1:0]               pend_y_reg;
    logic [7:0]                   pend_g_reg, pend_r_reg;

    // shared multiplier
    logic signed [31:0]           mul_a;
    logic signed [17:0]           mul_b;
    logic signed [49:0]           mul_p_reg;
    logic signed [50:0]           p51;

    // divider hookup
    logic                               div_start;
    logic signed [psur_pkg::DVD_W-1:0]  div_dvd;
    logic signed [psur_pkg::DVS_W-1:0]  div_dvs;
    logic                               div_done;
    logic signed [31:0]                 div_quot;

    // misc combinational
    logic                         s_acc;
    logic                         emit_go;
    logic [VC_W-1:0]              cnt_eff;
    logic                         load_ok;
    logic [VC_W-1:0]              nidx;
    logic [VI_W-1:0]              vaddr;
    logic [Y_W-1:0]               row_addr;
    logic                         swap_e;
    psur_pkg::vtx_t               top_n, bot_n;
    logic signed [16:0]           dy_e, dx_e, du_e, dv_e;
    logic signed [17:0]           et;
    logic [8:0]                   ys;
    logic signed [9:0]            bot_row;
    logic signed [17:0]           sk;
    logic [10:0]                  ek;
    logic signed [17:0]           st;
    logic signed [32:0]           ss_x, ss_u, ss_v;
    logic signed [31:0]           add_base;
    logic signed [31:0]           add_res;
    logic signed [50:0]           set_base;
    logic signed [50:0]           set_prod;
    logic signed [31:0]           set_res;
    psur_pkg::pt_t                cur_pt;
    logic                         swap_s;
    logic signed [16:0]           c0_n, c1_n;

    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // output register takes a new result this cycle
    assign emit_go = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    // vertex count as seen by a load
    assign cnt_eff = (phase_reg != PH_LOADING) ? '0 : vcount_reg;
    assign load_ok = (cnt_eff < VC_W'(psur_pkg::MAX_VERTICES));

    // vertex memory addressing: first endpoint, then its successor
    assign nidx  = edge_index_reg + 1'b1;
    assign vaddr = (state_reg == S_ES_RD0) ? edge_index_reg[VI_W-1:0] :
                   ((nidx == vcount_reg) ? '0 : nidx[VI_W-1:0]);

    always_ff @(posedge aclk) begin
        if (s_acc && (s_data.kind == psur_pkg::KIND_LOAD) && load_ok) begin
            vmem[cnt_eff[VI_W-1:0]] <= {s_data.vertex_x, s_data.vertex_y,
                                        s_data.vertex_u, s_data.vertex_v};
        end
        vrd_reg <= vmem[vaddr];
    end

    // row store: first edge point of each row
    assign row_addr = edge_row_reg[Y_W-1:0];

    always_ff @(posedge aclk) begin
        if ((state_reg == S_ER_W) && !row_seen_reg[row_addr]) begin
            rmem[row_addr] <= cur_pt;
        end
        rrd_reg <= rmem[row_addr];
    end

    // edge ordering top to bottom
    assign swap_e = (q0_reg.vertex_y > vrd_reg.vertex_y);
    assign top_n  = swap_e ? vrd_reg : q0_reg;
    assign bot_n  = swap_e ? q0_reg : vrd_reg;

    assign dy_e = {bot_reg.vertex_y[15], bot_reg.vertex_y}
                - {top_reg.vertex_y[15], top_reg.vertex_y};
    assign dx_e = {bot_reg.vertex_x[15], bot_reg.vertex_x}
                - {top_reg.vertex_x[15], top_reg.vertex_x};
    assign du_e = {bot_reg.vertex_u[15], bot_reg.vertex_u}
                - {top_reg.vertex_u[15], top_reg.vertex_u};
    assign dv_e = {bot_reg.vertex_v[15], bot_reg.vertex_v}
                - {top_reg.vertex_v[15], top_reg.vertex_v};

    // first sample row and its sub-pixel offset
    assign ys = top_reg.vertex_y[15] ? 9'd0 : top_reg.vertex_y[14:6];
    assign et = top_reg.vertex_y[15]
              ? (18'sd64 - {{2{top_reg.vertex_y[15]}}, top_reg.vertex_y})
              : (18'sd64 - $signed({12'b0, top_reg.vertex_y[5:0]}));
    assign bot_row = bot_reg.vertex_y[15:6];

    // step counts
    assign sk = {span_col_reg[16], span_col_reg} - {span_c0_reg[16], span_c0_reg};
    assign ek = edge_row_reg - {2'b0, edge_first_reg};

    // span differences and start offset
    assign ss_x = {sb_reg.x[31], sb_reg.x} - {sa_reg.x[31], sa_reg.x};
    assign ss_u = {sb_reg.u[31], sb_reg.u} - {sa_reg.u[31], sa_reg.u};
    assign ss_v = {sb_reg.v[31], sb_reg.v} - {sa_reg.v[31], sa_reg.v};
    assign st   = $signed({1'b0, 17'h10000 - {1'b0, sa_reg.x[15:0]}});

    // current edge point and span ordering
    assign cur_pt = '{x: cur_x_reg, u: cur_u_reg, v: add_res};
    assign swap_s = (rrd_reg.x > cur_x_reg);

    // span column bounds, truncated toward zero
    assign c0_n = {sa_reg.x[31], sa_reg.x[31:16]}
                + ((sa_reg.x[31] && (|sa_reg.x[15:0])) ? 17'sd1 : 17'sd0);
    assign c1_n = {sb_reg.x[31], sb_reg.x[31:16]}
                + ((sb_reg.x[31] && (|sb_reg.x[15:0])) ? 17'sd1 : 17'sd0);

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SP_U:  begin mul_a = span_du_reg; mul_b = sk; end
            S_SP_V:  begin mul_a = span_dv_reg; mul_b = sk; end
            S_ER_X:  begin mul_a = edge_dx_reg; mul_b = $signed({7'b0, ek}); end
            S_ER_U:  begin mul_a = edge_du_reg; mul_b = $signed({7'b0, ek}); end
            S_ER_V:  begin mul_a = edge_dv_reg; mul_b = $signed({7'b0, ek}); end
            S_SS_MU: begin mul_a = span_du_reg; mul_b = st; end
            S_SS_MV: begin mul_a = span_dv_reg; mul_b = st; end
            S_ES_MX: begin mul_a = edge_dx_reg; mul_b = et; end
            S_ES_MU: begin mul_a = edge_du_reg; mul_b = et; end
            S_ES_MV: begin mul_a = edge_dv_reg; mul_b = et; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    assign p51 = {mul_p_reg[49], mul_p_reg};

    // walk adder: start value plus slope times step count
    always_comb begin
        case (state_reg)
            S_SP_V:   add_base = span_u0_reg;
            S_SP_OUT: add_base = span_v0_reg;
            S_ER_U:   add_base = edge_x0_reg;
            S_ER_V:   add_base = edge_u0_reg;
            S_ER_W:   add_base = edge_v0_reg;
            default:  add_base = '0;
        endcase
    end
    assign add_res = psur_pkg::sat32({{19{add_base[31]}}, add_base} + p51);

    // setup adder: vertex or span start plus scaled product
    always_comb begin
        set_prod = p51 >>> 6;
        case (state_reg)
            S_SS_MV: begin
                set_base = {{19{sa_reg.u[31]}}, sa_reg.u};
                set_prod = p51 >>> 16;
            end
            S_SS_FIN: begin
                set_base = {{19{sa_reg.v[31]}}, sa_reg.v};
                set_prod = p51 >>> 16;
            end
            S_ES_MU:  set_base = {{25{top_reg.vertex_x[15]}}, top_reg.vertex_x, 10'b0};
            S_ES_MV:  set_base = {{30{top_reg.vertex_u[15]}}, top_reg.vertex_u, 5'b0};
            S_ES_FIN: set_base = {{30{top_reg.vertex_v[15]}}, top_reg.vertex_v, 5'b0};
            default:  set_base = '0;
        endcase
    end
    assign set_res = psur_pkg::sat32(set_base + set_prod);

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (state_reg)
            S_ES_DXS: begin
                div_start = 1'b1;
                div_dvd   = {{16{dx_e[16]}}, dx_e, 16'b0};
                div_dvs   = {{17{dy_e[16]}}, dy_e};
            end
            S_ES_DUS: begin
                div_start = 1'b1;
                div_dvd   = {{21{du_e[16]}}, du_e, 11'b0};
                div_dvs   = {{17{dy_e[16]}}, dy_e};
            end
            S_ES_DVS: begin
                div_start = 1'b1;
                div_dvd   = {{21{dv_e[16]}}, dv_e, 11'b0};
                div_dvs   = {{17{dy_e[16]}}, dy_e};
            end
            S_SS_DUS: begin
                div_start = (ss_x != '0);
                div_dvd   = {ss_u, 16'b0};
                div_dvs   = {ss_x[32], ss_x};
            end
            S_SS_DVS: begin
                div_start = 1'b1;
                div_dvd   = {ss_v, 16'b0};
                div_dvs   = {ss_x[32], ss_x};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    psur_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_LOADING;
            vcount_reg     <= '0;
            edge_index_reg <= '0;
            edge_on_reg    <= 1'b0;
            span_on_reg    <= 1'b0;
            first_reg      <= 1'b0;
            found_reg      <= 1'b0;
            row_seen_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit_go) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && (s_data.kind == psur_pkg::KIND_LOAD)) begin
                        phase_reg <= PH_LOADING;
                        if (load_ok) begin
                            vcount_reg <= cnt_eff + 1'b1;
                        end else begin
                            vcount_reg <= cnt_eff;
                        end
                    end else if (s_acc) begin
                        unique case (phase_reg)
                            PH_LOADING: begin
                                row_seen_reg   <= '0;
                                edge_index_reg <= '0;
                                edge_on_reg    <= 1'b0;
                                span_on_reg    <= 1'b0;
                                if (vcount_reg < VC_W'(2)) begin
                                    phase_reg <= PH_DONE;
                                    res_reg   <= '{empty_res: 1'b1, default: '0};
                                    state_reg <= S_EMIT;
                                end else begin
                                    first_reg <= 1'b1;
                                    state_reg <= S_FIND;
                                end
                            end
                            PH_RUNNING: begin
                                res_reg   <= '{pixel_x: pend_x_reg, pixel_y: pend_y_reg,
                                               green: pend_g_reg, red: pend_r_reg,
                                               last: 1'b0, empty_res: 1'b0};
                                state_reg <= S_FIND;
                            end
                            default: begin
                                res_reg   <= '{empty_res: 1'b1, default: '0};
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end

                // pick the next unit of work
                S_FIND: begin
                    if (span_on_reg) begin
                        if (span_col_reg < span_end_reg) begin
                            state_reg <= S_SP_U;
                        end else begin
                            span_on_reg <= 1'b0;
                        end
                    end else if (edge_on_reg) begin
                        if ($signed({1'b0, edge_row_reg}) <
                            $signed({edge_end_reg[10], edge_end_reg})) begin
                            state_reg <= S_ER_X;
                        end else begin
                            edge_on_reg    <= 1'b0;
                            edge_index_reg <= edge_index_reg + 1'b1;
                        end
                    end else if (edge_index_reg >= vcount_reg) begin
                        found_reg <= 1'b0;
                        state_reg <= S_RETURN;
                    end else begin
                        state_reg <= S_ES_RD0;
                    end
                end

                S_RETURN: begin
                    if (first_reg) begin
                        first_reg <= 1'b0;
                        if (!found_reg) begin
                            phase_reg <= PH_DONE;
                            res_reg   <= '{empty_res: 1'b1, default: '0};
                            state_reg <= S_EMIT;
                        end else begin
                            phase_reg <= PH_RUNNING;
                            res_reg   <= '{pixel_x: pend_x_reg, pixel_y: pend_y_reg,
                                           green: pend_g_reg, red: pend_r_reg,
                                           last: 1'b0, empty_res: 1'b0};
                            state_reg <= S_FIND;
                        end
                    end else begin
                        res_reg.last <= !found_reg;
                        if (!found_reg) begin
                            phase_reg <= PH_DONE;
                        end
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (emit_go) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                // span pixel
                S_SP_U: state_reg <= S_SP_V;
                S_SP_V: begin
                    pend_g_reg <= psur_pkg::colour(add_res);
                    state_reg  <= S_SP_OUT;
                end
                S_SP_OUT: begin
                    pend_r_reg   <= psur_pkg::colour(add_res);
                    pend_x_reg   <= span_col_reg[X_W-1:0];
                    pend_y_reg   <= span_y_reg;
                    span_col_reg <= span_col_reg + 17'sd1;
                    found_reg    <= 1'b1;
                    state_reg    <= S_RETURN;
                end

                // edge row
                S_ER_X: state_reg <= S_ER_U;
                S_ER_U: begin
                    cur_x_reg <= add_res;
                    state_reg <= S_ER_V;
                end
                S_ER_V: begin
                    cur_u_reg <= add_res;
                    state_reg <= S_ER_W;
                end
                S_ER_W: begin
                    edge_row_reg <= edge_row_reg + 1'b1;
                    if (row_seen_reg[row_addr]) begin
                        sa_reg     <= swap_s ? cur_pt : rrd_reg;
                        sb_reg     <= swap_s ? rrd_reg : cur_pt;
                        span_y_reg <= row_addr;
                        state_reg  <= S_SS_DUS;
                    end else begin
                        row_seen_reg[row_addr] <= 1'b1;
                        state_reg              <= S_FIND;
                    end
                end

                // span setup
                S_SS_DUS: begin
                    if (ss_x == '0) begin
                        span_du_reg <= '0;
                        span_dv_reg <= '0;
                        state_reg   <= S_SS_MU;
                    end else begin
                        state_reg <= S_SS_DUW;
                    end
                end
                S_SS_DUW: begin
                    if (div_done) begin
                        span_du_reg <= div_quot;
                        state_reg   <= S_SS_DVS;
                    end
                end
                S_SS_DVS: state_reg <= S_SS_DVW;
                S_SS_DVW: begin
                    if (div_done) begin
                        span_dv_reg <= div_quot;
                        state_reg   <= S_SS_MU;
                    end
                end
                S_SS_MU: state_reg <= S_SS_MV;
                S_SS_MV: begin
                    span_u0_reg <= set_res;
                    state_reg   <= S_SS_FIN;
                end
                S_SS_FIN: begin
                    span_v0_reg  <= set_res;
                    span_c0_reg  <= c0_n;
                    span_col_reg <= c0_n[16] ? 17'sd0 : c0_n;
                    span_end_reg <= (c1_n > 17'(psur_pkg::CANVAS_WIDTH))
                                  ? 17'(psur_pkg::CANVAS_WIDTH) : c1_n;
                    span_on_reg  <= 1'b1;
                    state_reg    <= S_FIND;
                end

                // edge setup
                S_ES_RD0: state_reg <= S_ES_RD1;
                S_ES_RD1: begin
                    q0_reg    <= vrd_reg;
                    state_reg <= S_ES_RD2;
                end
                S_ES_RD2: begin
                    top_reg <= top_n;
                    bot_reg <= bot_n;
                    if (q0_reg.vertex_y == vrd_reg.vertex_y) begin
                        edge_index_reg <= edge_index_reg + 1'b1;
                        state_reg      <= S_FIND;
                    end else begin
                        state_reg <= S_ES_DXS;
                    end
                end
                S_ES_DXS: state_reg <= S_ES_DXW;
                S_ES_DXW: begin
                    if (div_done) begin
                        edge_dx_reg <= div_quot;
                        state_reg   <= S_ES_DUS;
                    end
                end
                S_ES_DUS: state_reg <= S_ES_DUW;
                S_ES_DUW: begin
                    if (div_done) begin
                        edge_du_reg <= div_quot;
                        state_reg   <= S_ES_DVS;
                    end
                end
                S_ES_DVS: state_reg <= S_ES_DVW;
                S_ES_DVW: begin
                    if (div_done) begin
                        edge_dv_reg <= div_quot;
                        state_reg   <= S_ES_MX;
                    end
                end
                S_ES_MX: state_reg <= S_ES_MU;
                S_ES_MU: begin
                    edge_x0_reg <= set_res;
                    state_reg   <= S_ES_MV;
                end
                S_ES_MV: begin
                    edge_u0_reg <= set_res;
                    state_reg   <= S_ES_FIN;
                end
                S_ES_FIN: begin
                    edge_v0_reg    <= set_res;
                    edge_first_reg <= ys;
                    edge_row_reg   <= {2'b0, ys};
                    edge_end_reg   <= ($signed({bot_row[9], bot_row}) >
                                       11'(psur_pkg::CANVAS_HEIGHT))
                                    ? 11'(psur_pkg::CANVAS_HEIGHT)
                                    : {bot_row[9], bot_row};
                    edge_on_reg    <= 1'b1;
                    state_reg      <= S_FIND;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `PSUR_ASSERT_IMP(a_empty_clean, aclk, aresetn, m_valid_reg && m_data_reg.empty_res, (m_data_reg.pixel_x == '0) && (m_data_reg.pixel_y == '0) && (m_data_reg.green == '0) && (m_data_reg.red == '0) && !m_data_reg.last)
    `PSUR_ASSERT_IMP(a_div_waiting, aclk, aresetn, div_done, (state_reg == S_ES_DXW) || (state_reg == S_ES_DUW) || (state_reg == S_ES_DVW) || (state_reg == S_SS_DUW) || (state_reg == S_SS_DVW))
    `PSUR_ASSERT_NXT(a_step_runs, aclk, aresetn, s_valid && s_ready && (s_data.kind == psur_pkg::KIND_STEP), state_reg != S_IDLE)

endmodule

`default_nettype wire

// File: rtl/core/psur_div.sv
// ----------------------------------------------------------------------------
// psur_div
// Bit-serial signed divider, truncating toward zero, result clamped to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module psur_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [psur_pkg::DVD_W-1:0] dividend,
    input  wire logic signed [psur_pkg::DVS_W-1:0] divisor,
    output logic                                   done,
    output logic signed [31:0]                     quot
);

    localparam int CNT_W = $clog2(psur_pkg::DVD_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [psur_pkg::DVD_W-1:0]  q_reg;
    logic [psur_pkg::DVS_W:0]    r_reg;
    logic [psur_pkg::DVS_W-1:0]  d_reg;

    logic [psur_pkg::DVD_W-1:0]  dvd_mag;
    logic [psur_pkg::DVS_W-1:0]  dvs_mag;
    logic [psur_pkg::DVS_W:0]    r_sh;
    logic                        fits;
    logic                        big_neg;

    // operand magnitudes
    assign dvd_mag = dividend[psur_pkg::DVD_W-1] ? (~dividend + 1'b1) : dividend;
    assign dvs_mag = divisor[psur_pkg::DVS_W-1] ? (~divisor + 1'b1) : divisor;

    // one restoring step
    assign r_sh = {r_reg[psur_pkg::DVS_W-1:0], q_reg[psur_pkg::DVD_W-1]};
    assign fits = (r_sh >= {1'b0, d_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[psur_pkg::DVD_W-1] ^ divisor[psur_pkg::DVS_W-1];
                q_reg    <= dvd_mag;
                d_reg    <= dvs_mag;
                r_reg    <= '0;
                cnt_reg  <= CNT_W'(psur_pkg::DVD_W);
            end else if (busy_reg) begin
                r_reg   <= fits ? (r_sh - {1'b0, d_reg}) : r_sh;
                q_reg   <= {q_reg[psur_pkg::DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // sign and clamp
    assign big_neg = (|q_reg[psur_pkg::DVD_W-1:32]) || (q_reg[31] && (|q_reg[30:0]));

    always_comb begin
        if (!neg_reg) begin
            quot = (|q_reg[psur_pkg::DVD_W-1:31]) ? 32'sh7FFF_FFFF : {1'b0, q_reg[30:0]};
        end else begin
            quot = big_neg ? 32'sh8000_0000 : (~q_reg[31:0] + 32'd1);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire
